FILE: rtl/core/assert_macros.svh
// Assertion macros for the point segment distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("psd assertion failed");
`define PSD_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("psd implication failed");
`else
`define PSD_ASSERT(name, clk, rstn, prop)
`define PSD_IMPLY(name, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/psd_pkg.sv
`default_nettype none
package psd_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W = 32;
    localparam int DIST_W = 33;
    localparam int S_TDATA_W = 6 * FIELD_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        NC_FOOT  = 2'd0,
        NC_START = 2'd1,
        NC_END   = 2'd2
    } near_case_t;
endpackage
`default_nettype wire

FILE: rtl/core/psd_prep.sv
`default_nettype none
module psd_prep #(
    parameter int CW = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [psd_pkg::S_TDATA_W-1:0] s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [4*CW+3:0]                    m_num,
    output logic [2*CW+2:0]                    m_den,
    output psd_pkg::near_case_t                m_kind
);
    import psd_pkg::*;

    localparam int NST = 6;
    localparam int PW = 2 * CW + 2;
    localparam int SW = 2 * CW + 3;
    localparam int H = CW + 2;
    localparam int NW = 4 * CW + 4;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic signed [CW:0] px, py, ax, ay, bx, by;
    logic signed [CW:0] dx_reg, dy_reg, l_reg, r_reg, ex_reg, ey_reg;
    logic               degen1_reg, degen2_reg, degen3_reg;
    logic signed [PW-1:0] dxl_reg, dyr_reg, exl_reg, eyr_reg, dyl_reg, dxr_reg;
    logic signed [PW-1:0] dxdx_reg, dydy_reg, exex_reg, eyey_reg, ll_reg, rr_reg;
    logic signed [SW-1:0] t1, t2, cr_reg;
    logic                 t1neg_reg, t2neg_reg;
    logic [SW-1:0]        sqd_reg, sqe_reg, den3_reg;
    near_case_t           kind4_reg, kind5_reg, kind_reg;
    logic [SW-1:0]        acr_reg, small4_reg, den4_reg, small5_reg, den5_reg;
    logic [SW-1:0]        acr_next;
    logic [2*H-1:0]       pll_reg;
    logic [H+CW:0]        plh_reg;
    logic [2*CW+1:0]      phh_reg;
    logic [NW-1:0]        num_reg;
    logic [SW-1:0]        den_reg;
    near_case_t           kind4_next;
    logic [SW-1:0]        small4_next, den4_next;

    assign rdy[NST] = m_ready;
    for (genvar i = 0; i < NST; i++) begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end
    assign s_ready = rdy[0];
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // sign extend the low CW bits of each coordinate
    assign px = {s_data[0*FIELD_W+CW-1], s_data[0*FIELD_W +: CW]};
    assign py = {s_data[1*FIELD_W+CW-1], s_data[1*FIELD_W +: CW]};
    assign ax = {s_data[2*FIELD_W+CW-1], s_data[2*FIELD_W +: CW]};
    assign ay = {s_data[3*FIELD_W+CW-1], s_data[3*FIELD_W +: CW]};
    assign bx = {s_data[4*FIELD_W+CW-1], s_data[4*FIELD_W +: CW]};
    assign by = {s_data[5*FIELD_W+CW-1], s_data[5*FIELD_W +: CW]};

    assign t1 = SW'(dxl_reg) + SW'(dyr_reg);
    assign t2 = SW'(exl_reg) + SW'(eyr_reg);

    always_comb
    begin
        acr_next = cr_reg[SW-1] ? SW'(-cr_reg) : SW'(cr_reg);
        if (degen3_reg || t1neg_reg)
        begin
            kind4_next  = NC_START;
            small4_next = sqd_reg;
            den4_next   = SW'(1);
        end
        else if (t2neg_reg)
        begin
            kind4_next  = NC_END;
            small4_next = sqe_reg;
            den4_next   = SW'(1);
        end
        else
        begin
            kind4_next  = NC_FOOT;
            small4_next = sqd_reg;
            den4_next   = den3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            dx_reg     <= px - ax;
            dy_reg     <= py - ay;
            l_reg      <= bx - ax;
            r_reg      <= by - ay;
            ex_reg     <= bx - px;
            ey_reg     <= by - py;
            degen1_reg <= (bx == ax) && (by == ay);
        end
        if (rdy[1])
        begin
            dxl_reg    <= PW'(dx_reg) * PW'(l_reg);
            dyr_reg    <= PW'(dy_reg) * PW'(r_reg);
            exl_reg    <= PW'(ex_reg) * PW'(l_reg);
            eyr_reg    <= PW'(ey_reg) * PW'(r_reg);
            dyl_reg    <= PW'(dy_reg) * PW'(l_reg);
            dxr_reg    <= PW'(dx_reg) * PW'(r_reg);
            dxdx_reg   <= PW'(dx_reg) * PW'(dx_reg);
            dydy_reg   <= PW'(dy_reg) * PW'(dy_reg);
            exex_reg   <= PW'(ex_reg) * PW'(ex_reg);
            eyey_reg   <= PW'(ey_reg) * PW'(ey_reg);
            ll_reg     <= PW'(l_reg) * PW'(l_reg);
            rr_reg     <= PW'(r_reg) * PW'(r_reg);
            degen2_reg <= degen1_reg;
        end
        if (rdy[2])
        begin
            t1neg_reg  <= t1[SW-1];
            t2neg_reg  <= t2[SW-1];
            cr_reg     <= SW'(dyl_reg) - SW'(dxr_reg);
            sqd_reg    <= SW'(dxdx_reg) + SW'(dydy_reg);
            sqe_reg    <= SW'(exex_reg) + SW'(eyey_reg);
            den3_reg   <= SW'(ll_reg) + SW'(rr_reg);
            degen3_reg <= degen2_reg;
        end
        if (rdy[3])
        begin
            kind4_reg  <= kind4_next;
            small4_reg <= small4_next;
            den4_reg   <= den4_next;
            acr_reg    <= acr_next;
        end
        if (rdy[4])
        begin
            pll_reg    <= (2*H)'(acr_reg[H-1:0]) * (2*H)'(acr_reg[H-1:0]);
            plh_reg    <= (H+CW+1)'(acr_reg[H-1:0]) * (H+CW+1)'(acr_reg[SW-1:H]);
            phh_reg    <= (2*CW+2)'(acr_reg[SW-1:H]) * (2*CW+2)'(acr_reg[SW-1:H]);
            kind5_reg  <= kind4_reg;
            small5_reg <= small4_reg;
            den5_reg   <= den4_reg;
        end
        if (rdy[5])
        begin
            num_reg  <= (kind5_reg == NC_FOOT)
                ? NW'((NW+2)'(phh_reg) << (2*H)) + NW'((NW+2)'(plh_reg) << (H+1))
                  + NW'(pll_reg)
                : NW'(small5_reg);
            den_reg  <= den5_reg;
            kind_reg <= kind5_reg;
        end
    end

    assign m_num  = num_reg;
    assign m_den  = den_reg;
    assign m_kind = kind_reg;
endmodule
`default_nettype wire

FILE: rtl/core/psd_cell.sv
`default_nettype none
`include "assert_macros.svh"
module psd_cell #(
    parameter int CW = 32,
    parameter int BIT = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [4*CW+3:0] s_rem,
    input  wire logic [4*CW+3:0] s_dd,
    input  wire logic [2*CW+2:0] s_den,
    input  wire logic [CW:0]     s_dist,
    input  wire psd_pkg::near_case_t s_kind,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [4*CW+3:0]      m_rem,
    output logic [4*CW+3:0]      m_dd,
    output logic [2*CW+2:0]      m_den,
    output logic [CW:0]          m_dist,
    output psd_pkg::near_case_t  m_kind
);
    import psd_pkg::*;

    localparam int NW = 4 * CW + 4;
    localparam int TW = NW + 2;

    logic            valid_reg;
    logic [NW-1:0]   rem_reg, dd_reg, rem_next, dd_next;
    logic [2*CW+2:0] den_reg;
    logic [CW:0]     dist_reg, dist_next;
    near_case_t      kind_reg;
    logic [TW-1:0]   term;
    logic            take;

    assign s_ready = !valid_reg || m_ready;

    // trial: (d + 2^k)^2 den - d^2 den = 2^(k+1) d den + 2^(2k) den
    always_comb
    begin
        term      = (TW'(s_dd) << (BIT + 1)) + (TW'(s_den) << (2 * BIT));
        take      = TW'(s_rem) >= term;
        rem_next  = take ? NW'(TW'(s_rem) - term) : s_rem;
        dd_next   = take ? s_dd + (NW'(s_den) << BIT) : s_dd;
        dist_next = take ? (s_dist | ((CW+1)'(1) << BIT)) : s_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready)
        begin
            rem_reg  <= rem_next;
            dd_reg   <= dd_next;
            den_reg  <= s_den;
            dist_reg <= dist_next;
            kind_reg <= s_kind;
        end
    end

    assign m_valid = valid_reg;
    assign m_rem   = rem_reg;
    assign m_dd    = dd_reg;
    assign m_den   = den_reg;
    assign m_dist  = dist_reg;
    assign m_kind  = kind_reg;

    `PSD_IMPLY(a_low_bits_clear, clk, rst_n, valid_reg,
               (dist_reg & (((CW+1)'(1) << BIT) - (CW+1)'(1))) == '0)
    `PSD_IMPLY(a_vertex_den_one, clk, rst_n, valid_reg && kind_reg != NC_FOOT,
               den_reg == (2*CW+3)'(1))
endmodule
`default_nettype wire

FILE: rtl/core/point_segment_distance.sv
// channel  dir  tdata (low bit up)                                tuser
// s_axis   in   point_x, point_y, start_x, start_y, end_x, end_y  -
// m_axis   out  distance (33b, zero padded to 40)                 nearest_case
// One word accepted per cycle unless a stall on m_tready backs up to s_tready.
// Six front stages form the differences, products and squared numerator and
// denominator; a row of COORD_WIDTH+1 cells then settles one root bit each.
// rst_n clears only the valid bits; payload registers are not reset.
// A stall on m_tready holds each full stage with no empty stage after it; empty stages keep filling.
`default_nettype none
`include "assert_macros.svh"
module point_segment_distance #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y
    input  wire logic [psd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // distance, zero pad
    output logic [psd_pkg::M_TDATA_W-1:0]      m_tdata,
    // nearest_case
    output logic [psd_pkg::M_TUSER_W-1:0]      m_tuser
);
    import psd_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = 4 * CW + 4;
    localparam int NCELL = CW + 1;

    logic            vld_w [NCELL+1];
    logic            rdy_w [NCELL+1];
    logic [NW-1:0]   rem_w [NCELL+1];
    logic [NW-1:0]   dd_w  [NCELL+1];
    logic [2*CW+2:0] den_w [NCELL+1];
    logic [CW:0]     dist_w[NCELL+1];
    near_case_t      kind_w[NCELL+1];

    psd_prep #(.CW(CW)) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  (s_tdata),
        .m_valid (vld_w[0]),
        .m_ready (rdy_w[0]),
        .m_num   (rem_w[0]),
        .m_den   (den_w[0]),
        .m_kind  (kind_w[0])
    );
    assign dd_w[0]   = '0;
    assign dist_w[0] = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        psd_cell #(.CW(CW), .BIT(CW - i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .s_valid (vld_w[i]),
            .s_ready (rdy_w[i]),
            .s_rem   (rem_w[i]),
            .s_dd    (dd_w[i]),
            .s_den   (den_w[i]),
            .s_dist  (dist_w[i]),
            .s_kind  (kind_w[i]),
            .m_valid (vld_w[i+1]),
            .m_ready (rdy_w[i+1]),
            .m_rem   (rem_w[i+1]),
            .m_dd    (dd_w[i+1]),
            .m_den   (den_w[i+1]),
            .m_dist  (dist_w[i+1]),
            .m_kind  (kind_w[i+1])
        );
    end

    assign rdy_w[NCELL] = m_tready;
    assign m_tvalid     = vld_w[NCELL];
    assign m_tdata      = M_TDATA_W'(dist_w[NCELL]);
    assign m_tuser      = M_TUSER_W'(kind_w[NCELL]);

    `PSD_IMPLY(a_stall_source, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    `PSD_IMPLY(a_case_code, clk, rst_n, m_tvalid,
               m_tuser == NC_FOOT || m_tuser == NC_START || m_tuser == NC_END)
endmodule
`default_nettype wire
